### hw/rtl/mil_pkg.sv
package mil_pkg;

  localparam int unsigned MaxTilePixels = 65536;
  localparam int unsigned MaxTiles      = 1024;
  localparam int unsigned CountW        = 17;
  localparam int unsigned TileIdxW      = 10;
  localparam int unsigned GainW         = 16;
  localparam int unsigned LikW          = 16;
  localparam int unsigned DivW          = 42;
  localparam int unsigned SeriesTerms   = 16;
  localparam int unsigned SquareSteps   = 8;

  typedef struct packed {
    logic [7:0] mask_pixel;
    logic [7:0] rendered_pixel;
    logic       last_pixel;
  } in_beat_t;

  typedef struct packed {
    logic [LikW-1:0]     likelihood_value;
    logic [CountW-1:0]   intersection_count;
    logic [CountW-1:0]   union_count;
    logic                empty_union;
    logic [TileIdxW-1:0] tile_index;
  } out_beat_t;

  // closed tile as handed from front to back
  typedef struct packed {
    logic [CountW-1:0]   and_count;
    logic [CountW-1:0]   or_count;
    logic [TileIdxW-1:0] tile_index;
  } tile_sum_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_SER_MUL,
    ST_CLAMP,
    ST_SQR,
    ST_FIN,
    ST_OUT
  } back_state_t;

endpackage

### hw/rtl/mil_front.sv
module mil_front
  import mil_pkg::*;
#(
  parameter int unsigned MAX_TILE_PIXELS = MaxTilePixels,
  parameter int unsigned MAX_TILES       = MaxTiles
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      push,
  output tile_sum_t push_data,
  input  logic      q_full
);

  localparam int unsigned Cap   = (MAX_TILE_PIXELS > 131071) ? 131071 : MAX_TILE_PIXELS;
  localparam int unsigned TileW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;

  logic [CountW-1:0] and_counter, and_next;
  logic [CountW-1:0] or_counter, or_next;
  logic [TileW-1:0]  tile_counter;
  logic              accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    and_next = and_counter;
    or_next  = or_counter;
    if (((in_data.mask_pixel & in_data.rendered_pixel) != 8'd0) &&
        (and_counter < CountW'(Cap))) begin
      and_next = and_counter + 1'b1;
    end
    if (((in_data.mask_pixel | in_data.rendered_pixel) != 8'd0) &&
        (or_counter < CountW'(Cap))) begin
      or_next = or_counter + 1'b1;
    end
  end

  assign push                 = accept && in_data.last_pixel;
  assign push_data.and_count  = and_next;
  assign push_data.or_count   = or_next;
  assign push_data.tile_index = TileIdxW'(32'(tile_counter));

  always_ff @(posedge clk) begin
    if (rst) begin
      and_counter  <= '0;
      or_counter   <= '0;
      tile_counter <= '0;
    end else if (accept) begin
      if (in_data.last_pixel) begin
        and_counter <= '0;
        or_counter  <= '0;
        if (32'(tile_counter) == MAX_TILES - 1) begin
          tile_counter <= '0;
        end else begin
          tile_counter <= tile_counter + 1'b1;
        end
      end else begin
        and_counter <= and_next;
        or_counter  <= or_next;
      end
    end
  end

  a_and_le_or: assert property (@(posedge clk) disable iff (rst)
    and_counter <= or_counter) else $error("intersection above union");

endmodule

### hw/rtl/mil_fifo.sv
module mil_fifo
  import mil_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  tile_sum_t push_data,
  input  logic      pop,
  output tile_sum_t head,
  output logic      not_empty,
  output logic      full
);

  tile_sum_t  mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign not_empty = count != 2'd0;
  assign full      = count == 2'd2;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2) else $error("queue over depth");

endmodule

### hw/rtl/mil_back.sv
module mil_back
  import mil_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [GainW-1:0] gain,
  input  logic             q_not_empty,
  input  tile_sum_t        q_head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output out_beat_t        out_data
);

  back_state_t state, state_next;

  tile_sum_t          cur;
  logic [DivW-1:0]    num, quo;
  logic [CountW-1:0]  rem, divisor;
  logic [5:0]         div_cnt;
  logic               series;
  logic [23:0]        y;
  logic [31:0]        term;
  logic signed [34:0] sum;
  logic [4:0]         n;
  logic [31:0]        e;
  logic [2:0]         sq_cnt;

  logic [CountW:0]    trial, trial_diff;
  logic               ge;
  logic [DivW-1:0]    q_fin;
  logic               div_done;
  logic [32:0]        prod_main;
  logic [55:0]        prod_ser;
  logic [63:0]        sq;
  logic [17:0]        rnd;

  // restoring divider, one quotient bit per cycle
  assign trial      = {rem, num[DivW-1]};
  assign ge         = trial >= {1'b0, divisor};
  assign trial_diff = trial - {1'b0, divisor};
  assign q_fin      = {quo[DivW-2:0], ge};
  assign div_done   = div_cnt == 6'(DivW - 1);

  assign prod_main = gain * (cur.or_count - cur.and_count);
  assign prod_ser  = term * y;
  assign sq        = e * e + 64'(33'h040000000);
  // (e + 2^14) >> 15
  assign rnd       = {1'b0, e[31:15]} + 18'(e[14]);

  assign pop       = (state == ST_IDLE) && q_not_empty;
  assign out_valid = state == ST_OUT;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_not_empty) begin
          state_next = (q_head.or_count == '0) ? ST_OUT : ST_MUL;
        end
      end
      ST_MUL:     state_next = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          if (!series) begin
            state_next = ST_SER_MUL;
          end else begin
            state_next = (n == 5'(SeriesTerms)) ? ST_CLAMP : ST_SER_MUL;
          end
        end
      end
      ST_SER_MUL: state_next = ST_DIV;
      ST_CLAMP:   state_next = ST_SQR;
      ST_SQR:     if (sq_cnt == 3'(SquareSteps - 1)) state_next = ST_FIN;
      ST_FIN:     state_next = ST_OUT;
      ST_OUT:     if (out_ready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cur <= q_head;
        if (q_head.or_count == '0) begin
          out_data.likelihood_value   <= '0;
          out_data.intersection_count <= '0;
          out_data.union_count        <= '0;
          out_data.empty_union        <= 1'b1;
          out_data.tile_index         <= q_head.tile_index;
        end
      end
      ST_MUL: begin
        // gain*(U-I)*256 + U/2, rounded quotient by U
        num     <= {1'b0, prod_main, 8'b0} + DivW'(cur.or_count >> 1);
        divisor <= cur.or_count;
        rem     <= '0;
        quo     <= '0;
        div_cnt <= '0;
        series  <= 1'b0;
      end
      ST_DIV: begin
        rem     <= ge ? trial_diff[CountW-1:0] : trial[CountW-1:0];
        num     <= num << 1;
        quo     <= q_fin;
        div_cnt <= div_cnt + 6'd1;
        if (div_done) begin
          if (!series) begin
            y    <= (q_fin[DivW-1:24] != '0) ? 24'hFFFFFF : q_fin[23:0];
            term <= 32'h80000000;
            sum  <= 35'sh080000000;
            n    <= 5'd1;
          end else begin
            term <= q_fin[31:0];
            if (n[0]) begin
              sum <= sum - $signed({3'b0, q_fin[31:0]});
            end else begin
              sum <= sum + $signed({3'b0, q_fin[31:0]});
            end
            n <= n + 5'd1;
          end
        end
      end
      ST_SER_MUL: begin
        // next term: (term*y >> 24) / n
        num     <= DivW'(prod_ser >> 24);
        divisor <= CountW'(n);
        rem     <= '0;
        quo     <= '0;
        div_cnt <= '0;
        series  <= 1'b1;
      end
      ST_CLAMP: begin
        if (sum < 0) begin
          e <= '0;
        end else if (sum > 35'sh080000000) begin
          e <= 32'h80000000;
        end else begin
          e <= sum[31:0];
        end
        sq_cnt <= '0;
      end
      ST_SQR: begin
        e      <= sq[62:31];
        sq_cnt <= sq_cnt + 3'd1;
      end
      ST_FIN: begin
        out_data.likelihood_value   <= (rnd > 18'd65535) ? 16'hFFFF : rnd[15:0];
        out_data.intersection_count <= cur.and_count;
        out_data.union_count        <= cur.or_count;
        out_data.empty_union        <= 1'b0;
        out_data.tile_index         <= cur.tile_index;
      end
      default: begin
      end
    endcase
  end

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.empty_union |-> out_data.likelihood_value == '0)
    else $error("empty union with nonzero likelihood");

  a_empty_iff_u0: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.empty_union == (out_data.union_count == '0)))
    else $error("empty flag disagrees with union");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> state != ST_IDLE) else $error("pop without leaving idle");

endmodule

### hw/rtl/mask_iou_likelihood_core.sv
// channel | dir | handshake           | payload
// in      | in  | in_valid/in_ready   | in_data (mask_pixel, rendered_pixel, last_pixel)
// out     | out | out_valid/out_ready | out_data (likelihood, counts, empty flag, tile)
// cfg     | in  | cfg_we              | cfg_wdata (exponent gain)
//
// pixels are taken one beat per cycle while the two-entry tile queue has room
// a tile holds the back end from pop to the first cycle its result is offered:
//   pop, setup, a 42-bit divide for the exponent, 16 series terms of one multiply
//   plus a 42-bit divide by n, clamp, 8 squares, rounding; empty union: straight to output
// synchronous reset clears counters, queue and state; gain returns to 1.0
// a stalled output holds the back end, and the front keeps accepting pixels
//   until two closed tiles wait in the queue
module mask_iou_likelihood_core
  import mil_pkg::*;
#(
  parameter int unsigned MAX_TILE_PIXELS = MaxTilePixels,
  parameter int unsigned MAX_TILES       = MaxTiles
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_beat_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_beat_t        out_data,
  input  logic             cfg_we,
  input  logic [GainW-1:0] cfg_wdata
);

  logic [GainW-1:0] exp_gain;
  logic             push, pop, q_full, q_not_empty;
  tile_sum_t        push_data, q_head;

  // gain register, Q8.8, reset to 1.0
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_gain <= GainW'(256);
    end else if (cfg_we) begin
      exp_gain <= cfg_wdata;
    end
  end

  // front: per-pixel intersection/union counting
  mil_front #(
    .MAX_TILE_PIXELS(MAX_TILE_PIXELS),
    .MAX_TILES      (MAX_TILES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .push     (push),
    .push_data(push_data),
    .q_full   (q_full)
  );

  // closed tiles wait here for the evaluator
  mil_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .head     (q_head),
    .not_empty(q_not_empty),
    .full     (q_full)
  );

  // back: divide, exp series, squaring, result register
  mil_back u_back (
    .clk        (clk),
    .rst        (rst),
    .gain       (exp_gain),
    .q_not_empty(q_not_empty),
    .q_head     (q_head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

### tb/mask_iou_likelihood_checker.sv
`timescale 1ns / 1ps

module mask_iou_likelihood_checker
  import mil_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_ready,
  input  in_beat_t         in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  out_beat_t        out_data,
  input  logic             cfg_we,
  input  logic [GainW-1:0] cfg_wdata,
  output int               fail_count,
  output int               tiles_pending
);

  localparam int unsigned CountCap = (MaxTilePixels > 131071) ? 131071 : MaxTilePixels;

  logic [GainW-1:0] gain_q;
  int unsigned      and_cnt, or_cnt, tile_cnt;
  out_beat_t        expected_tiles[$];

  // exp(-gain*(1-I/U)) in Q0.16, series then repeated squaring
  function automatic logic [LikW-1:0] iou_likelihood(logic [GainW-1:0] g,
                                                     int unsigned ic, int unsigned uc);
    longint unsigned x, term, e, r;
    longint          acc;
    x = (longint'(g) * longint'(uc - ic) * 256 + uc / 2) / uc;
    if (x > 64'hFF_FFFF) x = 64'hFF_FFFF;
    acc  = 64'sd1 << 31;
    term = 64'd1 << 31;
    for (int n = 1; n <= 16; n++) begin
      term = ((term * x) >> 24) / n;
      if (n % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > (64'sd1 << 31)) acc = 64'sd1 << 31;
    e = acc;
    for (int k = 0; k < 8; k++) e = (e * e + (64'd1 << 30)) >> 31;
    r = (e + (64'd1 << 14)) >> 15;
    return (r > 65535) ? 16'hFFFF : r[15:0];
  endfunction

  always @(posedge clk) begin
    out_beat_t exp_b;
    if (rst) begin
      gain_q     <= 16'd256;
      and_cnt    = 0;
      or_cnt     = 0;
      tile_cnt   = 0;
      fail_count <= 0;
      expected_tiles.delete();
    end else begin
      if (cfg_we) gain_q <= cfg_wdata;
      if (in_valid && in_ready) begin
        if ((in_data.mask_pixel & in_data.rendered_pixel) != 0 && and_cnt < CountCap)
          and_cnt++;
        if ((in_data.mask_pixel | in_data.rendered_pixel) != 0 && or_cnt < CountCap)
          or_cnt++;
        if (in_data.last_pixel) begin
          exp_b.empty_union        = (or_cnt == 0);
          exp_b.likelihood_value   = (or_cnt == 0) ? '0 : iou_likelihood(gain_q, and_cnt, or_cnt);
          exp_b.intersection_count = and_cnt[CountW-1:0];
          exp_b.union_count        = or_cnt[CountW-1:0];
          exp_b.tile_index         = tile_cnt[TileIdxW-1:0];
          expected_tiles.push_back(exp_b);
          and_cnt  = 0;
          or_cnt   = 0;
          tile_cnt = (tile_cnt + 1) % MaxTiles;
        end
      end
      if (out_valid && out_ready) begin
        if (expected_tiles.size() == 0) begin
          $display("%0t: unexpected result beat %p", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          exp_b = expected_tiles.pop_front();
          if (out_data.likelihood_value !== exp_b.likelihood_value ||
              out_data.intersection_count !== exp_b.intersection_count ||
              out_data.union_count !== exp_b.union_count ||
              out_data.empty_union !== exp_b.empty_union ||
              out_data.tile_index !== exp_b.tile_index) begin
            $display("%0t: mismatch expected %p actual %p", $time, exp_b, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    tiles_pending <= expected_tiles.size();
  end

endmodule

### tb/mask_iou_likelihood_core_tb.sv
`timescale 1ns / 1ps

module mask_iou_likelihood_core_tb;
  import mil_pkg::*;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_beat_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_beat_t        out_data;
  logic             cfg_we = 1'b0;
  logic [GainW-1:0] cfg_wdata = '0;
  int               fail_count;
  int               tiles_pending;

  // idle percentages for the sending and receiving side
  int unsigned send_idle = 0;
  int unsigned recv_stall = 0;

  always #5 clk = ~clk;

  mask_iou_likelihood_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  mask_iou_likelihood_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .tiles_pending(tiles_pending)
  );

  // receiver stalls at random, one decision per cycle
  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall);

  // one pixel beat: optional idle gap, then hold valid until in_ready was seen
  task automatic send_pixel(input logic [7:0] m, input logic [7:0] p, input logic l);
    logic rdy;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{mask_pixel: m, rendered_pixel: p, last_pixel: l};
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
  endtask

  // wait for the back end to drain everything accepted so far
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tiles_pending != 0) @(posedge clk);
  endtask

  // gain write only when idle; drain already empties the back end, extra cycles add margin
  task automatic write_gain(input logic [GainW-1:0] g);
    drain();
    repeat (1000) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // random tile content: noise, empty, full overlap, disjoint-ish, masks of 0/255
  task automatic send_tile(input int unsigned len);
    logic [7:0] m, p;
    int unsigned style;
    style = $urandom_range(4);
    for (int unsigned k = 0; k < len; k++) begin
      m = 8'($urandom_range(255));
      p = 8'($urandom_range(255));
      case (style)
        0: ;
        1: if ($urandom_range(3) != 0) begin m = 8'd0; p = 8'd0; end
        2: p = ($urandom_range(3) == 0) ? ~m : m;
        3: begin m = {8{m[0]}}; p = {8{p[0]}}; end
        default: if ($urandom_range(1)) m = 8'd0;
      endcase
      send_pixel(m, p, k == len - 1);
    end
  endtask

  // directed corners, short tiles
  task automatic directed_tiles();
    send_pixel(8'h00, 8'h00, 1'b1);          // empty union
    send_pixel(8'hFF, 8'hFF, 1'b1);          // full overlap, iou one
    send_pixel(8'h0F, 8'hF0, 1'b1);          // union without intersection
    send_pixel(8'hFF, 8'h00, 1'b0);
    send_pixel(8'h00, 8'hFF, 1'b0);
    send_pixel(8'h80, 8'h81, 1'b0);
    send_pixel(8'h00, 8'h00, 1'b1);          // mixed tile, i=1 u=3
    send_pixel(8'h01, 8'h01, 1'b0);
    send_pixel(8'hAA, 8'h55, 1'b1);          // i=1 u=2
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset gain, then the extremes of the gain register, then the smallest nonzero gain
    directed_tiles();
    write_gain(16'd0);
    directed_tiles();
    write_gain(16'hFFFF);
    directed_tiles();
    write_gain(16'd1);
    directed_tiles();

    // random phases: no idling, sender idle, receiver stall, both
    for (int ph = 0; ph < 8; ph++) begin
      int unsigned sent;
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 46; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 46; end
        default: begin send_idle = 30; recv_stall = 30; end
      endcase
      write_gain(16'($urandom_range(65535)));
      sent = 0;
      while (sent < 120) begin
        int unsigned len;
        len = ($urandom_range(4) == 0) ? $urandom_range(40, 4) : $urandom_range(3, 1);
        send_tile(len);
        sent += len;
        // sender holds off once until the back end is empty
        if (ph == 3 && sent >= 60 && sent < 60 + len) drain();
      end
    end

    // tile index wrap: enough single-pixel tiles to pass the index limit
    send_idle  = 30;
    recv_stall = 30;
    for (int k = 0; k < MaxTiles + 8; k++)
      send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b1);

    drain();
    repeat (1000) @(posedge clk);
    if (fail_count == 0 && tiles_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // hang guard
  initial begin
    #100_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
